>>> rtl/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and the neighbour-mean function of the bilinear
// Bayer demosaic core.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int PIX_W        = 8;
  localparam int DIM_W        = 12;
  localparam int FRAME_H_MAX  = 2048;
  localparam int FRAME_W_MIN  = 2;
  localparam int FRAME_H_MIN  = 2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  // Register indexes on the configuration port.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming raw sample
    logic read;      // read both line stores, write the new sample
    logic pix_keep;  // sample is inside the frame and not a drain beat
    logic shift;     // shift the window, write back the upper line store
    logic load;      // load the output register
  } dp_cmd_t;

  // Neighbour availability, site color and frame-end flag of the pixel being produced.
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
    logic row_odd;
    logic col_odd;
    logic eof;
  } geom_t;

  // Truncated mean of up to four 8-bit samples. Division by three uses a
  // reciprocal multiply that is exact for sums up to 765.
  function automatic logic [PIX_W-1:0] mean_of(input logic [9:0] sum,
                                               input logic [2:0] cnt);
    logic [20:0] prod;
    logic [PIX_W-1:0] res;
    prod = {11'd0, sum} * 21'd683;
    unique case (cnt)
      3'd1:    res = sum[7:0];
      3'd2:    res = sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = sum[9:2];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bbd_raw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_raw_if
// Raw Bayer sample channel: valid/ready handshake with sample and drain flag.
// ----------------------------------------------------------------------------
interface bbd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_pixel;
  logic       drain;

  modport source (output valid, output raw_pixel, output drain, input ready);
  modport sink   (input valid, input raw_pixel, input drain, output ready);
endinterface
`default_nettype wire

>>> rtl/bbd_rgb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_rgb_if
// Reconstructed pixel channel: valid/ready handshake with RGB and frame end.
// ----------------------------------------------------------------------------
interface bbd_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       end_of_frame;

  modport source (output valid, output red, output green, output blue,
                  output end_of_frame, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input end_of_frame, output ready);
endinterface
`default_nettype wire

>>> rtl/bayer_bilinear_demosaic_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// Streaming bilinear Bayer demosaic with two line stores and a 3x3 window.
// ----------------------------------------------------------------------------
// Raw samples enter on raw_in in raster order (even rows G,B; odd rows R,G).
// Each beat carries raw_pixel and a drain flag; a drain beat advances the
// raster position without a sample. One RGB pixel leaves on rgb_out for each
// position, lagging the input by one row plus one position, so W+1 drain
// beats after a frame flush its last row. end_of_frame marks the last pixel.
// Frame width and height are set over the APB port (offset 0 and 4); the
// user writes them only while the block is idle, which the block does not
// enforce. Values are clamped to the supported range. Each accepted beat
// runs through a read, a shift and, when it yields a pixel, an output load
// step, ordered by the line store sequence (read, then write-back of the
// upper store); the load step registers the result onto rgb_out.
// The next beat is accepted while a finished pixel still waits in the output
// register; a stalled receiver holds the sequencer only in its load step.
// Reset returns the raster position to the frame origin, clears the window
// and restores 640x480. Line store contents are not cleared.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  bbd_raw_if.sink          raw_in,
  bbd_rgb_if.source        rgb_out
);

  localparam int DW    = bbd_pkg::DIM_W;
  localparam int COL_W = $clog2(MAX_LINE_PIXELS);

  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  logic          cfg_write;
  logic          reg_sel;

  bbd_pkg::dp_cmd_t cmd;
  bbd_pkg::geom_t   geom;
  logic [COL_W-1:0] addr;
  logic             out_busy;

  // Register select is the word offset; byte lanes inside a word alias.
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbd_pkg::FRAME_WIDTH_RESET;
      frame_height <= bbd_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        bbd_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[DW-1:0];
        bbd_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bbd_pkg::REG_FRAME_WIDTH:  prdata = {{(32-DW){1'b0}}, frame_width};
      bbd_pkg::REG_FRAME_HEIGHT: prdata = {{(32-DW){1'b0}}, frame_height};
      default:                   prdata = '0;
    endcase
  end

  bbd_ctrl #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .in_valid    (raw_in.valid),
    .in_drain    (raw_in.drain),
    .in_ready    (raw_in.ready),
    .out_busy    (out_busy),
    .cmd         (cmd),
    .geom        (geom),
    .addr        (addr)
  );

  bbd_datapath #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .geom        (geom),
    .addr        (addr),
    .raw_pixel   (raw_in.raw_pixel),
    .out_busy    (out_busy),
    .out_valid   (rgb_out.valid),
    .out_ready   (rgb_out.ready),
    .red         (rgb_out.red),
    .green       (rgb_out.green),
    .blue        (rgb_out.blue),
    .end_of_frame(rgb_out.end_of_frame)
  );

endmodule
`default_nettype wire

>>> rtl/bbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_ctrl
// Sequencer of the demosaic core: raster position, frame geometry checks and
// the command sequence for one beat.
// ----------------------------------------------------------------------------
module bbd_ctrl #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [bbd_pkg::DIM_W-1:0]         frame_width,
  input  wire logic [bbd_pkg::DIM_W-1:0]         frame_height,
  input  wire logic                              in_valid,
  input  wire logic                              in_drain,
  output logic                                   in_ready,
  input  wire logic                              out_busy,
  output bbd_pkg::dp_cmd_t                       cmd,
  output bbd_pkg::geom_t                         geom,
  output logic [$clog2(MAX_LINE_PIXELS)-1:0]     addr
);

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int EW_W  = $clog2(MAX_LINE_PIXELS + 1);
  localparam int CW    = (EW_W > bbd_pkg::DIM_W) ? EW_W : bbd_pkg::DIM_W;
  localparam int DW    = bbd_pkg::DIM_W;

  localparam logic [CW-1:0] EW_MAX = CW'(MAX_LINE_PIXELS);
  localparam logic [CW-1:0] EW_MIN = CW'(bbd_pkg::FRAME_W_MIN);
  localparam logic [DW-1:0] EH_MAX = DW'(bbd_pkg::FRAME_H_MAX);
  localparam logic [DW-1:0] EH_MIN = DW'(bbd_pkg::FRAME_H_MIN);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SHIFT, S_EMIT} state_t;

  state_t          state;
  logic [COL_W-1:0] column;
  logic [DW-1:0]    row;
  logic             drain_q;
  logic             emit_q;
  bbd_pkg::geom_t   geom_q;

  logic [CW-1:0] fw_ext;
  logic [CW-1:0] ew;
  logic [DW-1:0] eh;
  logic [DW-1:0] eh_plus2;
  logic [CW-1:0] col_ext;

  // Position normalization at accept.
  logic          col_wrap;
  logic [DW-1:0] row_t;
  logic [DW-1:0] row_n;
  logic [COL_W-1:0] col_n;

  // Geometry of the pixel to emit.
  logic          col0;
  logic [DW-1:0] er;
  logic [CW-1:0] ec;
  logic          emit_now;
  bbd_pkg::geom_t geom_now;

  // Advance after the beat.
  logic [CW-1:0] col_adv;
  logic [DW-1:0] row_adv;

  logic accept;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext < EW_MIN) begin
      ew = EW_MIN;
    end else if (fw_ext > EW_MAX) begin
      ew = EW_MAX;
    end else begin
      ew = fw_ext;
    end
    if (frame_height < EH_MIN) begin
      eh = EH_MIN;
    end else if (frame_height > EH_MAX) begin
      eh = EH_MAX;
    end else begin
      eh = frame_height;
    end
    eh_plus2 = eh + DW'(2);
    col_ext  = CW'(column);
  end

  always_comb begin
    col_wrap = (col_ext >= ew);
    row_t    = col_wrap ? row + DW'(1) : row;
    row_n    = (row_t >= eh_plus2) ? '0 : row_t;
    col_n    = col_wrap ? '0 : column;
  end

  always_comb begin
    col0     = (column == '0);
    er       = col0 ? row - DW'(2) : row - DW'(1);
    ec       = col0 ? ew - CW'(1) : col_ext - CW'(1);
    emit_now = (row >= (col0 ? DW'(2) : DW'(1))) && (er < eh);
    geom_now.up      = (er != '0);
    geom_now.dn      = ((er + DW'(1)) < eh);
    geom_now.lf      = (ec != '0);
    geom_now.rt      = ((ec + CW'(1)) < ew);
    geom_now.row_odd = er[0];
    geom_now.col_odd = ec[0];
    geom_now.eof     = ((er + DW'(1)) == eh) && ((ec + CW'(1)) == ew);
  end

  always_comb begin
    col_adv = col_ext + CW'(1);
    row_adv = row + DW'(1);
  end

  // No beat is taken while reset is held.
  assign accept   = (state == S_IDLE) && in_valid && !rst;
  assign in_ready = (state == S_IDLE) && !rst;
  assign addr     = column;
  assign geom     = geom_q;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.read     = (state == S_READ);
    cmd.pix_keep = (row < eh) && !drain_q;
    cmd.shift    = (state == S_SHIFT);
    cmd.load     = (state == S_EMIT) && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      column  <= '0;
      row     <= '0;
      drain_q <= 1'b0;
      emit_q  <= 1'b0;
      geom_q  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            column  <= col_n;
            row     <= row_n;
            drain_q <= in_drain;
            state   <= S_READ;
          end
        end
        S_READ: begin
          emit_q <= emit_now;
          geom_q <= geom_now;
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          if (col_adv >= ew) begin
            column <= '0;
            row    <= (row_adv >= eh_plus2) ? '0 : row_adv;
          end else begin
            column <= col_adv[COL_W-1:0];
          end
          state <= emit_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/bbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_datapath
// Line stores, 3x3 neighbour window, color reconstruction and the output
// register of the demosaic core.
// ----------------------------------------------------------------------------
module bbd_datapath #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bbd_pkg::dp_cmd_t                  cmd,
  input  wire bbd_pkg::geom_t                    geom,
  input  wire logic [$clog2(MAX_LINE_PIXELS)-1:0] addr,
  input  wire logic [bbd_pkg::PIX_W-1:0]         raw_pixel,
  output logic                                   out_busy,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bbd_pkg::PIX_W-1:0]              red,
  output logic [bbd_pkg::PIX_W-1:0]              green,
  output logic [bbd_pkg::PIX_W-1:0]              blue,
  output logic                                   end_of_frame
);

  localparam int PW = bbd_pkg::PIX_W;

  logic [PW-1:0] upper_line_store  [MAX_LINE_PIXELS];
  logic [PW-1:0] middle_line_store [MAX_LINE_PIXELS];

  logic [PW-1:0] raw_q;
  logic [PW-1:0] pix_q;
  logic [PW-1:0] top_q;
  logic [PW-1:0] mid_q;
  logic [PW-1:0] win [9];

  logic [PW-1:0] pix_g;

  logic [8:0] vs;
  logic [8:0] hs;
  logic [9:0] ds;
  logic [9:0] vh;
  logic [2:0] vn;
  logic [2:0] hn;
  logic [2:0] dnum;
  logic [PW-1:0] r_c;
  logic [PW-1:0] g_c;
  logic [PW-1:0] b_c;

  assign pix_g = cmd.pix_keep ? raw_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_q <= raw_pixel;
    end
  end

  // Middle store: read the old row, write the new sample at the same column.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      mid_q                   <= middle_line_store[addr];
      middle_line_store[addr] <= pix_g;
      pix_q                   <= pix_g;
    end
  end

  // Upper store: read in the read step, take the old middle row one step later.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      top_q <= upper_line_store[addr];
    end
    if (cmd.shift) begin
      upper_line_store[addr] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= top_q;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid_q;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= pix_q;
    end
  end

  // Neighbour sums around the window center.
  always_comb begin
    vs   = (geom.up ? {1'b0, win[1]} : 9'd0) + (geom.dn ? {1'b0, win[7]} : 9'd0);
    vn   = {2'b00, geom.up} + {2'b00, geom.dn};
    hs   = (geom.lf ? {1'b0, win[3]} : 9'd0) + (geom.rt ? {1'b0, win[5]} : 9'd0);
    hn   = {2'b00, geom.lf} + {2'b00, geom.rt};
    ds   = ((geom.up && geom.lf) ? {2'b00, win[0]} : 10'd0)
         + ((geom.up && geom.rt) ? {2'b00, win[2]} : 10'd0)
         + ((geom.dn && geom.lf) ? {2'b00, win[6]} : 10'd0)
         + ((geom.dn && geom.rt) ? {2'b00, win[8]} : 10'd0);
    dnum = {2'b00, geom.up && geom.lf} + {2'b00, geom.up && geom.rt}
         + {2'b00, geom.dn && geom.lf} + {2'b00, geom.dn && geom.rt};
    vh   = {1'b0, vs} + {1'b0, hs};
  end

  always_comb begin
    unique case ({geom.row_odd, geom.col_odd})
      2'b00: begin
        r_c = bbd_pkg::mean_of({1'b0, vs}, vn);
        g_c = win[4];
        b_c = bbd_pkg::mean_of({1'b0, hs}, hn);
      end
      2'b01: begin
        r_c = bbd_pkg::mean_of(ds, dnum);
        g_c = bbd_pkg::mean_of(vh, vn + hn);
        b_c = win[4];
      end
      2'b10: begin
        r_c = win[4];
        g_c = bbd_pkg::mean_of(vh, vn + hn);
        b_c = bbd_pkg::mean_of(ds, dnum);
      end
      default: begin
        r_c = bbd_pkg::mean_of({1'b0, hs}, hn);
        g_c = win[4];
        b_c = bbd_pkg::mean_of({1'b0, vs}, vn);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red          <= r_c;
      green        <= g_c;
      blue         <= b_c;
      end_of_frame <= geom.eof;
    end
  end

  assign out_busy = out_valid && !out_ready;

endmodule
`default_nettype wire
